/* sv/assert_macros.svh */
// Assertion macros shared by the debug port master RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is high.
`define C2M_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define C2M_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/c2m_pkg.sv */
// Shared types, codes and helper functions for the two-wire debug port master.
// No dependencies; imported by every module of the block.
package c2m_pkg;

   // command opcodes
   localparam logic [2:0] OP_RESET   = 3'd0;
   localparam logic [2:0] OP_WR_ADDR = 3'd1;
   localparam logic [2:0] OP_RD_ADDR = 3'd2;
   localparam logic [2:0] OP_WR_DATA = 3'd3;
   localparam logic [2:0] OP_RD_DATA = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [1:0] CSR_RESET_LOW   = 2'd1;
   localparam logic [1:0] CSR_WAIT_LIMIT  = 2'd2;

   localparam int CSR_DATA_W = 10;

   localparam logic [7:0] HALF_PERIOD_RST = 8'd1;
   localparam logic [9:0] RESET_LOW_RST   = 10'd25;
   localparam logic [7:0] WAIT_LIMIT_RST  = 8'd20;

   // sequencer phases
   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_RST_LOW  = 4'd1;
   localparam logic [3:0] PH_RST_HIGH = 4'd2;
   localparam logic [3:0] PH_START    = 4'd3;
   localparam logic [3:0] PH_INS      = 4'd4;
   localparam logic [3:0] PH_LEN      = 4'd5;
   localparam logic [3:0] PH_WRITE    = 4'd6;
   localparam logic [3:0] PH_WAIT     = 4'd7;
   localparam logic [3:0] PH_READ     = 4'd8;
   localparam logic [3:0] PH_STOP     = 4'd9;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] opcode;
      logic [7:0] wr_byte;
      logic       data_pin_in;
   } req_type;

   typedef struct packed {
      logic       clock_pin;
      logic       data_drive_en;
      logic       data_pin_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rd_byte;
      logic       error;
   } rsp_type;

   // effective timing settings, zero already mapped to one
   typedef struct packed {
      logic [7:0] half;
      logic [9:0] rlow;
      logic [7:0] wlim;
   } cfg_type;

   // instruction bit sent in the INS field, LSB first
   function automatic logic ins_bit(input logic [2:0] op, input logic idx);
      logic [1:0] code;
      begin
         unique case (op)
            OP_WR_ADDR: code = 2'd3;
            OP_RD_ADDR: code = 2'd2;
            OP_WR_DATA: code = 2'd1;
            default:    code = 2'd0;
         endcase
         ins_bit = code[idx];
      end
   endfunction

   // field that follows the given one for an access type
   function automatic logic [3:0] field_after(input logic [2:0] op, input logic [3:0] ph);
      logic data_acc;
      begin
         data_acc = (op == OP_WR_DATA) || (op == OP_RD_DATA);
         unique case (ph)
            PH_START: field_after = PH_INS;
            PH_INS: begin
               if (data_acc) field_after = PH_LEN;
               else if (op == OP_WR_ADDR) field_after = PH_WRITE;
               else field_after = PH_READ;
            end
            PH_LEN:   field_after = (op == OP_WR_DATA) ? PH_WRITE : PH_WAIT;
            PH_WRITE: field_after = data_acc ? PH_WAIT : PH_STOP;
            PH_WAIT:  field_after = (op == OP_RD_DATA) ? PH_READ : PH_STOP;
            default:  field_after = PH_STOP;
         endcase
      end
   endfunction

endpackage

/* sv/c2m_csr.sv */
// Timing configuration registers of the debug port master.
// Depends on c2m_pkg for register indexes, reset values and cfg_type.
module c2m_csr
   import c2m_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [7:0] half_ff, half_in;
   logic [9:0] rlow_ff, rlow_in;
   logic [7:0] wlim_ff, wlim_in;

   always_comb begin
      half_in = half_ff;
      rlow_in = rlow_ff;
      wlim_in = wlim_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HALF_PERIOD: half_in = csr_wdata[7:0];
            CSR_RESET_LOW:   rlow_in = csr_wdata;
            CSR_WAIT_LIMIT:  wlim_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= HALF_PERIOD_RST;
         rlow_ff <= RESET_LOW_RST;
         wlim_ff <= WAIT_LIMIT_RST;
      end else begin
         half_ff <= half_in;
         rlow_ff <= rlow_in;
         wlim_ff <= wlim_in;
      end
   end

   // a zero setting behaves as one
   assign cfg.half = (half_ff == 8'd0) ? 8'd1 : half_ff;
   assign cfg.rlow = (rlow_ff == 10'd0) ? 10'd1 : rlow_ff;
   assign cfg.wlim = (wlim_ff == 8'd0) ? 8'd1 : wlim_ff;

endmodule

/* sv/c2m_core.sv */
// Pin sequencer of the debug port master: phase state and one tick of work per step.
// Depends on c2m_pkg; checks use assert_macros.svh.
`include "assert_macros.svh"
module c2m_core
   import c2m_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   logic [3:0] phase_ff, phase_in;
   logic [2:0] op_ff, op_in;
   logic [3:0] bit_index_ff, bit_index_in;
   logic [7:0] shift_ff, shift_in;
   logic [9:0] timer_ff, timer_in;
   logic [7:0] wait_cnt_ff, wait_cnt_in;
   logic       clock_ff, clock_in;
   logic       dir_ff, dir_in;
   logic       level_ff, level_in;

   logic [2:0] op_eff;
   logic       strobe_end;

   always_comb begin
      phase_in     = phase_ff;
      op_in        = op_ff;
      bit_index_in = bit_index_ff;
      shift_in     = shift_ff;
      timer_in     = timer_ff;
      wait_cnt_in  = wait_cnt_ff;
      clock_in     = clock_ff;
      dir_in       = dir_ff;
      level_in     = level_ff;
      op_eff       = OP_RD_DATA;
      strobe_end   = 1'b0;
      rsp          = '0;

      if (phase_ff == PH_IDLE && req.cmd_valid && req.opcode <= OP_RD_DATA) begin
         op_in        = req.opcode;
         shift_in     = req.wr_byte;
         timer_in     = '0;
         bit_index_in = '0;
         wait_cnt_in  = '0;
         phase_in     = (req.opcode == OP_RESET) ? PH_RST_LOW : PH_START;
      end

      if (phase_in == PH_IDLE) begin
         clock_in = 1'b1;
      end else if (phase_in == PH_RST_LOW) begin
         rsp.busy_res = 1'b1;
         clock_in     = 1'b0;
         dir_in       = 1'b0;
         timer_in     = timer_in + 10'd1;
         if (timer_in >= cfg.rlow) begin
            timer_in = '0;
            phase_in = PH_RST_HIGH;
         end
      end else if (phase_in == PH_RST_HIGH) begin
         rsp.busy_res = 1'b1;
         rsp.done_res = 1'b1;
         clock_in     = 1'b1;
         phase_in     = PH_IDLE;
      end else begin
         op_eff       = (op_in <= OP_RD_DATA) ? op_in : OP_RD_DATA;
         rsp.busy_res = 1'b1;
         unique case (phase_in)
            PH_INS: begin
               dir_in   = 1'b1;
               level_in = ins_bit(op_eff, bit_index_in[0]);
            end
            PH_LEN: begin
               dir_in   = 1'b1;
               level_in = 1'b0;
            end
            PH_WRITE: begin
               dir_in   = 1'b1;
               level_in = shift_in[0];
            end
            PH_WAIT, PH_READ, PH_STOP: dir_in = 1'b0;
            default: ;
         endcase
         // low half then high half of the strobe
         clock_in   = (timer_in < {2'b00, cfg.half}) ? 1'b0 : 1'b1;
         strobe_end = ({1'b0, timer_in} + 11'd1) >= {2'b00, cfg.half, 1'b0};

         if (strobe_end) begin
            timer_in = '0;
            unique case (phase_in)
               PH_START: begin
                  phase_in     = field_after(op_eff, phase_in);
                  bit_index_in = '0;
               end
               PH_INS, PH_LEN: begin
                  bit_index_in = bit_index_in + 4'd1;
                  if (bit_index_in >= 4'd2) begin
                     phase_in     = field_after(op_eff, phase_in);
                     bit_index_in = '0;
                     if (phase_in == PH_READ) shift_in = '0;
                  end
               end
               PH_WRITE: begin
                  shift_in     = {1'b0, shift_in[7:1]};
                  bit_index_in = bit_index_in + 4'd1;
                  if (bit_index_in >= 4'd8) begin
                     phase_in     = field_after(op_eff, phase_in);
                     bit_index_in = '0;
                  end
               end
               PH_WAIT: begin
                  if (req.data_pin_in) begin
                     phase_in     = field_after(op_eff, phase_in);
                     bit_index_in = '0;
                     if (phase_in == PH_READ) shift_in = '0;
                  end else begin
                     wait_cnt_in = wait_cnt_in + 8'd1;
                     // timeout ends the access with no STOP
                     if (wait_cnt_in >= cfg.wlim || wait_cnt_in == 8'd0) begin
                        rsp.done_res = 1'b1;
                        rsp.error    = 1'b1;
                        phase_in     = PH_IDLE;
                     end
                  end
               end
               PH_READ: begin
                  shift_in     = {req.data_pin_in, shift_in[7:1]};
                  bit_index_in = bit_index_in + 4'd1;
                  if (bit_index_in >= 4'd8) begin
                     phase_in     = field_after(op_eff, phase_in);
                     bit_index_in = '0;
                  end
               end
               default: begin
                  rsp.done_res = 1'b1;
                  if (op_eff == OP_RD_ADDR || op_eff == OP_RD_DATA) rsp.rd_byte = shift_in;
                  phase_in = PH_IDLE;
               end
            endcase
         end else begin
            timer_in = timer_in + 10'd1;
         end
      end

      rsp.clock_pin     = clock_in;
      rsp.data_drive_en = dir_in;
      rsp.data_pin_out  = level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         op_ff        <= OP_RESET;
         bit_index_ff <= '0;
         shift_ff     <= '0;
         timer_ff     <= '0;
         wait_cnt_ff  <= '0;
         clock_ff     <= 1'b1;
         dir_ff       <= 1'b0;
         level_ff     <= 1'b0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         op_ff        <= op_in;
         bit_index_ff <= bit_index_in;
         shift_ff     <= shift_in;
         timer_ff     <= timer_in;
         wait_cnt_ff  <= wait_cnt_in;
         clock_ff     <= clock_in;
         dir_ff       <= dir_in;
         level_ff     <= level_in;
      end
   end

   `C2M_ASSERT(a_done_goes_idle, clock, reset, step_en && rsp.done_res |=> phase_ff == PH_IDLE, "done tick did not return to idle")
   `C2M_ASSERT(a_error_no_byte, clock, reset, step_en && rsp.error |-> rsp.done_res && rsp.rd_byte == 8'd0, "error without done or with data")
   `C2M_ASSERT(a_idle_clock_high, clock, reset, step_en && !rsp.busy_res |-> rsp.clock_pin && !rsp.done_res, "idle tick with clock low or done")
   `C2M_ASSERT(a_bit_index_range, clock, reset, bit_index_ff <= 4'd8, "bit index out of range")

endmodule

/* sv/two_wire_debug_port_master.sv */
// Top level of the two-wire debug port master: request and response registers around the
// pin sequencer. Depends on c2m_pkg, c2m_csr, c2m_core and assert_macros.svh.
//
//   port group   direction   handshake            payload
//   req_*        in          req_valid/req_ready  req_type: command and sampled data pin
//   rsp_*        out         rsp_valid/rsp_ready  rsp_type: pin levels, busy, done, byte
//   csr_*        in          csr_we               csr_index, csr_wdata
//
// One request per clock sustained while responses are taken; each request is one pin tick
// and yields one response. A request passes a request register, then the sequencer step into
// the response reg. The sequencer step only advances when the response register can take
// its result; a stalled response backs up into req_ready.
// Reset is synchronous and active high; no clearing pass is needed.
`include "assert_macros.svh"
module two_wire_debug_port_master
   import c2m_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   logic    step_en;
   logic    req_take;
   cfg_type cfg;
   rsp_type step_rsp;

   c2m_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   c2m_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   assign step_en   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_en;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !step_en);
   assign out_valid_in = step_en || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_data_ff <= req_data;
      if (step_en) out_data_ff <= step_rsp;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `C2M_ASSERT(a_step_fills_output, clock, reset, step_en |=> out_valid_ff, "stepped request produced no response")
   `C2M_ASSERT(a_stall_holds_request, clock, reset, in_valid_ff && !step_en |=> in_valid_ff && $stable(in_data_ff), "pending request lost")

endmodule
